@@ rtl/core/bbt_pkg.sv @@
// ----------------------------------------------------------------------------
// Bad block table package
// Shared types and constants for the bad block table and its compare cells.
// ----------------------------------------------------------------------------
package bbt_pkg;

  typedef enum logic [1:0] {
    FUNC_CHECK = 2'd0,
    FUNC_MARK  = 2'd1,
    FUNC_FIND  = 2'd2,
    FUNC_SAFE  = 2'd3
  } bbt_func_e;

  typedef struct packed {
    logic        vld;
    logic        last;
    logic        hit;
    logic [15:0] blk;
  } bbt_tok_t;

  localparam logic [15:0] TOTAL_RESET = 16'd2048;
  localparam logic [15:0] NONE_BLOCK  = 16'hFFFF;
  localparam logic [31:0] NONE_ADDR   = 32'hFFFF_FFFF;

endpackage

@@ rtl/core/bbt_req_if.sv @@
// ----------------------------------------------------------------------------
// Bad block table request channel
// Valid/ready channel carrying one table request.
// ----------------------------------------------------------------------------
interface bbt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] block_number;
  logic [31:0] byte_address;
  logic        target_is_nand;

  modport source (output valid, func, block_number, byte_address, target_is_nand,
                  input ready);
  modport sink   (input valid, func, block_number, byte_address, target_is_nand,
                  output ready);
endinterface

@@ rtl/core/bbt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Bad block table response channel
// Valid/ready channel carrying one table response.
// ----------------------------------------------------------------------------
interface bbt_rsp_if;
  logic        valid;
  logic        ready;
  logic        block_is_bad;
  logic        success;
  logic [15:0] found_block;
  logic [31:0] safe_address;

  modport source (output valid, block_is_bad, success, found_block, safe_address,
                  input ready);
  modport sink   (input valid, block_is_bad, success, found_block, safe_address,
                  output ready);
endinterface

@@ rtl/core/bbt_cell.sv @@
// ----------------------------------------------------------------------------
// Bad block table cell
// Holds one table entry and compares it against the lookup token passing by.
// ----------------------------------------------------------------------------
module bbt_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CW-1:0]    cnt_i,
  input  logic             wr_i,
  input  logic [15:0]      wr_data_i,
  input  logic             flush_i,
  input  bbt_pkg::bbt_tok_t tok_i,
  output bbt_pkg::bbt_tok_t tok_o
);

  logic [15:0] entry_q;
  logic        vld_q;
  logic        last_q;
  logic        hit_q;
  logic [15:0] blk_q;
  logic        occupied;

  assign occupied = CW'(IDX) < cnt_i;

  always_ff @(posedge clk_i) begin
    if (wr_i && (cnt_i == CW'(IDX))) begin
      entry_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= tok_i.vld && !flush_i;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= tok_i.last;
    hit_q  <= tok_i.hit | (occupied && (entry_q == tok_i.blk));
    blk_q  <= tok_i.blk;
  end

  assign tok_o = '{vld: vld_q, last: last_q, hit: hit_q, blk: blk_q};

endmodule

@@ rtl/core/bad_block_table_manager_unit.sv @@
// ----------------------------------------------------------------------------
// Bad block table manager
// Keeps the list of bad erase blocks and answers check, mark, search and
// safe write address requests.
// ----------------------------------------------------------------------------
// Requests arrive on the in_i channel and each produces exactly one response
// transfer on out_o. The block serves one request at a time; in_i is ready
// whenever no request is in progress, even while a response waits in the
// output register. The table is a row of MAX_BAD_BLOCKS cells, one entry
// each; a lookup token walks the row one cell per cycle. A search feeds one
// candidate block per cycle into the row. A safe address request on a good
// block costs one lookup, on a bad block a lookup and a search, and for another
// device or a block beyond 16 bits no lookup. Reset empties the list and sets
// the block count to 2048; no clearing pass is needed. If the receiver stalls,
// the finished response is held and the next request may still be taken but
// waits before its response.
// ----------------------------------------------------------------------------
module bad_block_table_manager_unit #(
  parameter int unsigned MAX_BAD_BLOCKS   = 128,
  parameter int unsigned BLOCK_BYTES_LOG2 = 17
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  bbt_req_if.sink     in_i,
  bbt_rsp_if.source   out_o
);
  import bbt_pkg::*;

  localparam int unsigned CW = $clog2(MAX_BAD_BLOCKS + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOOK = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e      state_q, state_d;
  logic [15:0] total_q;
  logic [CW-1:0] cnt_q;

  bbt_func_e   func_q;
  logic [15:0] blk_q;
  logic [31:0] addr_q;

  logic [16:0] cand_q, cand_d;
  logic [16:0] start_q, start_d;
  logic        pass_q, pass_d;
  logic        gen_done_q, gen_done_d;

  logic        res_bad_q, res_bad_d;
  logic        res_ok_q, res_ok_d;
  logic [15:0] res_found_q, res_found_d;
  logic [31:0] res_safe_q, res_safe_d;

  logic        out_vld_q;
  logic        out_bad_q, out_ok_q;
  logic [15:0] out_found_q;
  logic [31:0] out_safe_q;

  bbt_tok_t    tok [MAX_BAD_BLOCKS+1];
  bbt_tok_t    tok_in;
  bbt_tok_t    tok_exit;
  logic        flush;
  logic        wr_en;

  logic        accept;
  bbt_func_e   in_func;
  logic [31:0] cur_full;
  logic        in_range;
  logic        out_free;

  assign accept   = in_i.valid && in_i.ready;
  assign in_func  = bbt_func_e'(in_i.func);
  assign cur_full = in_i.byte_address >> BLOCK_BYTES_LOG2;
  assign in_range = (cur_full[31:16] == 16'd0);
  assign out_free = !out_vld_q || out_o.ready;
  assign tok[0]   = tok_in;
  assign tok_exit = tok[MAX_BAD_BLOCKS];

  assign in_i.ready = (state_q == ST_IDLE);

  for (genvar i = 0; i < MAX_BAD_BLOCKS; i++) begin : g_cell
    bbt_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cnt_i     (cnt_q),
      .wr_i      (wr_en),
      .wr_data_i (blk_q),
      .flush_i   (flush),
      .tok_i     (tok[i]),
      .tok_o     (tok[i+1])
    );
  end

  always_comb begin
    tok_in = '0;
    if ((state_q == ST_IDLE) && accept) begin
      if ((in_func == FUNC_CHECK) || (in_func == FUNC_MARK)) begin
        tok_in.vld = 1'b1;
        tok_in.blk = in_i.block_number;
      end else if ((in_func == FUNC_SAFE) && in_i.target_is_nand && in_range) begin
        tok_in.vld = 1'b1;
        tok_in.blk = cur_full[15:0];
      end
    end else if ((state_q == ST_SCAN) && !gen_done_q) begin
      if (!pass_q) begin
        if (cand_q < {1'b0, total_q}) begin
          tok_in.vld = 1'b1;
          tok_in.blk = cand_q[15:0];
        end
      end else if (cand_q < start_q) begin
        tok_in.vld = 1'b1;
        tok_in.blk = cand_q[15:0];
      end else begin
        tok_in.vld  = 1'b1;
        tok_in.last = 1'b1;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cand_d      = cand_q;
    start_d     = start_q;
    pass_d      = pass_q;
    gen_done_d  = gen_done_q;
    res_bad_d   = res_bad_q;
    res_ok_d    = res_ok_q;
    res_found_d = res_found_q;
    res_safe_d  = res_safe_q;
    flush       = 1'b0;
    wr_en       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_bad_d   = 1'b0;
          res_ok_d    = 1'b0;
          res_found_d = 16'd0;
          res_safe_d  = 32'd0;
          unique case (in_func)
            FUNC_CHECK, FUNC_MARK: begin
              state_d = ST_LOOK;
            end
            FUNC_FIND: begin
              start_d    = {1'b0, in_i.block_number};
              cand_d     = {1'b0, in_i.block_number};
              pass_d     = 1'b0;
              gen_done_d = 1'b0;
              state_d    = ST_SCAN;
            end
            FUNC_SAFE: begin
              if (in_i.target_is_nand && in_range) begin
                state_d = ST_LOOK;
              end else begin
                res_ok_d   = 1'b1;
                res_safe_d = in_i.byte_address;
                state_d    = ST_FIN;
              end
            end
            default: begin
              state_d = ST_FIN;
            end
          endcase
        end
      end

      ST_LOOK: begin
        if (tok_exit.vld) begin
          state_d = ST_FIN;
          unique case (func_q)
            FUNC_CHECK: begin
              res_bad_d = tok_exit.hit;
            end
            FUNC_MARK: begin
              if (tok_exit.hit) begin
                res_ok_d = 1'b1;
              end else if (cnt_q < CW'(MAX_BAD_BLOCKS)) begin
                res_ok_d = 1'b1;
                wr_en    = 1'b1;
              end
            end
            FUNC_SAFE: begin
              if (!tok_exit.hit) begin
                res_ok_d   = 1'b1;
                res_safe_d = addr_q;
              end else begin
                res_bad_d  = 1'b1;
                start_d    = {1'b0, blk_q} + 17'd1;
                cand_d     = {1'b0, blk_q} + 17'd1;
                pass_d     = 1'b0;
                gen_done_d = 1'b0;
                state_d    = ST_SCAN;
              end
            end
            default: begin
              res_ok_d = 1'b0;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (!gen_done_q) begin
          if (!pass_q) begin
            if (cand_q < {1'b0, total_q}) begin
              cand_d = cand_q + 17'd1;
            end else begin
              pass_d = 1'b1;
              cand_d = 17'd0;
            end
          end else if (cand_q < start_q) begin
            cand_d = cand_q + 17'd1;
          end else begin
            gen_done_d = 1'b1;
          end
        end
        if (tok_exit.vld && (tok_exit.last || !tok_exit.hit)) begin
          flush   = 1'b1;
          state_d = ST_FIN;
          if (tok_exit.last) begin
            res_ok_d = 1'b0;
            if (func_q == FUNC_SAFE) begin
              res_safe_d = NONE_ADDR;
            end else begin
              res_found_d = NONE_BLOCK;
            end
          end else begin
            res_ok_d = 1'b1;
            if (func_q == FUNC_SAFE) begin
              res_safe_d = 32'(tok_exit.blk) << BLOCK_BYTES_LOG2;
            end else begin
              res_found_d = tok_exit.blk;
            end
          end
        end
      end

      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      total_q    <= TOTAL_RESET;
      cnt_q      <= '0;
      pass_q     <= 1'b0;
      gen_done_q <= 1'b1;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      pass_q     <= pass_d;
      gen_done_q <= gen_done_d;
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
      end
      if (wr_en) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if ((state_q == ST_FIN) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q      <= cand_d;
    start_q     <= start_d;
    res_bad_q   <= res_bad_d;
    res_ok_q    <= res_ok_d;
    res_found_q <= res_found_d;
    res_safe_q  <= res_safe_d;
    if (accept) begin
      func_q <= in_func;
      addr_q <= in_i.byte_address;
      blk_q  <= (in_func == FUNC_SAFE) ? cur_full[15:0] : in_i.block_number;
    end
    if ((state_q == ST_FIN) && out_free) begin
      out_bad_q   <= res_bad_q;
      out_ok_q    <= res_ok_q;
      out_found_q <= res_found_q;
      out_safe_q  <= res_safe_q;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.block_is_bad = out_bad_q;
  assign out_o.success      = out_ok_q;
  assign out_o.found_block  = out_found_q;
  assign out_o.safe_address = out_safe_q;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bad block table manager testbench
// Walks a short directed table and then random requests through the block.
// Random idle cycles are applied on the request side and on the response side.
// The block count register is written at several values, both extremes among
// them. Every response transfer is compared with a local model of the bad block
// list and its search rules, or with the response typed in a directed row.
// ----------------------------------------------------------------------------
module testbench;
  import bbt_pkg::*;

  localparam int unsigned MAX_ENTRIES = 128;
  localparam int unsigned BLK_SHIFT   = 17;
  localparam int          RAND_SEGS   = 6;
  localparam int          SEG_ITEMS   = 215;

  typedef struct packed {
    bbt_func_e   func;
    logic [15:0] blk;
    logic [31:0] addr;
    logic        to_nand;
  } req_t;

  typedef struct packed {
    logic        is_bad;
    logic        success;
    logic [15:0] found;
    logic [31:0] safe_addr;
  } rsp_t;

  typedef struct packed {
    logic        wr_cfg;
    logic [15:0] cfg_val;
    bbt_func_e   func;
    logic [15:0] blk;
    logic [31:0] addr;
    logic        to_nand;
    logic        typed;
    rsp_t        rsp;
  } dir_row_t;

  localparam int N_DIR = 23;
  localparam dir_row_t DIRECTED [N_DIR] = '{
    '{1'b0, 16'd0,     FUNC_CHECK, 16'd0,     32'h0000_0000, 1'b0, 1'b1,
      '{1'b0, 1'b0, 16'h0000, 32'h0000_0000}},
    '{1'b0, 16'd0,     FUNC_FIND,  16'd0,     32'h0000_0000, 1'b0, 1'b1,
      '{1'b0, 1'b1, 16'h0000, 32'h0000_0000}},
    '{1'b0, 16'd0,     FUNC_FIND,  16'hFFFF,  32'h0000_0000, 1'b0, 1'b1,
      '{1'b0, 1'b1, 16'h0000, 32'h0000_0000}},
    '{1'b0, 16'd0,     FUNC_SAFE,  16'd0,     32'hFFFF_FFFF, 1'b0, 1'b1,
      '{1'b0, 1'b1, 16'h0000, 32'hFFFF_FFFF}},
    '{1'b0, 16'd0,     FUNC_SAFE,  16'd0,     32'h1234_5678, 1'b1, 1'b1,
      '{1'b0, 1'b1, 16'h0000, 32'h1234_5678}},
    '{1'b0, 16'd0,     FUNC_MARK,  16'd0,     32'h0000_0000, 1'b0, 1'b1,
      '{1'b0, 1'b1, 16'h0000, 32'h0000_0000}},
    '{1'b0, 16'd0,     FUNC_MARK,  16'd1,     32'h0000_0000, 1'b0, 1'b1,
      '{1'b0, 1'b1, 16'h0000, 32'h0000_0000}},
    '{1'b0, 16'd0,     FUNC_MARK,  16'd0,     32'h0000_0000, 1'b0, 1'b1,
      '{1'b0, 1'b1, 16'h0000, 32'h0000_0000}},
    '{1'b0, 16'd0,     FUNC_CHECK, 16'd1,     32'h0000_0000, 1'b0, 1'b1,
      '{1'b1, 1'b0, 16'h0000, 32'h0000_0000}},
    '{1'b0, 16'd0,     FUNC_CHECK, 16'hFFFF,  32'h0000_0000, 1'b0, 1'b1,
      '{1'b0, 1'b0, 16'h0000, 32'h0000_0000}},
    '{1'b0, 16'd0,     FUNC_MARK,  16'hFFFF,  32'h0000_0000, 1'b0, 1'b1,
      '{1'b0, 1'b1, 16'h0000, 32'h0000_0000}},
    '{1'b0, 16'd0,     FUNC_CHECK, 16'hFFFF,  32'h0000_0000, 1'b0, 1'b1,
      '{1'b1, 1'b0, 16'h0000, 32'h0000_0000}},
    '{1'b0, 16'd0,     FUNC_MARK,  16'h7FFF,  32'h0000_0000, 1'b0, 1'b1,
      '{1'b0, 1'b1, 16'h0000, 32'h0000_0000}},
    '{1'b0, 16'd0,     FUNC_FIND,  16'd0,     32'h0000_0000, 1'b0, 1'b0, '0},
    '{1'b1, 16'hFFFF,  FUNC_SAFE,  16'd0,     32'hFFFE_0000, 1'b1, 1'b1,
      '{1'b1, 1'b1, 16'h0000, 32'h0000_0000}},
    '{1'b0, 16'd0,     FUNC_FIND,  16'hFFFF,  32'h0000_0000, 1'b0, 1'b0, '0},
    '{1'b0, 16'd0,     FUNC_SAFE,  16'd0,     32'h0000_1234, 1'b1, 1'b0, '0},
    '{1'b1, 16'd2,     FUNC_SAFE,  16'd0,     32'h0002_0000, 1'b1, 1'b1,
      '{1'b1, 1'b0, 16'h0000, 32'hFFFF_FFFF}},
    '{1'b0, 16'd0,     FUNC_FIND,  16'd0,     32'h0000_0000, 1'b0, 1'b1,
      '{1'b0, 1'b0, 16'hFFFF, 32'h0000_0000}},
    '{1'b1, 16'd0,     FUNC_FIND,  16'd0,     32'h0000_0000, 1'b0, 1'b1,
      '{1'b0, 1'b0, 16'hFFFF, 32'h0000_0000}},
    '{1'b0, 16'd0,     FUNC_FIND,  16'd5,     32'h0000_0000, 1'b0, 1'b0, '0},
    '{1'b0, 16'd0,     FUNC_CHECK, 16'hAAAA,  32'h5555_AAAA, 1'b1, 1'b1,
      '{1'b0, 1'b0, 16'h0000, 32'h0000_0000}},
    '{1'b0, 16'd0,     FUNC_SAFE,  16'h5555,  32'hAAAA_5555, 1'b0, 1'b1,
      '{1'b0, 1'b1, 16'h0000, 32'hAAAA_5555}}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  bbt_req_if req_ch ();
  bbt_rsp_if rsp_ch ();

  logic [15:0] marked_blks[$];
  logic [15:0] total_cfg;
  rsp_t        pending_rsps[$];
  int unsigned mismatch_cnt;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;

  bad_block_table_manager_unit #(
    .MAX_BAD_BLOCKS  (MAX_ENTRIES),
    .BLOCK_BYTES_LOG2(BLK_SHIFT)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (req_ch),
    .out_o      (rsp_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic is_listed(input logic [31:0] b);
    foreach (marked_blks[i]) begin
      if ({16'd0, marked_blks[i]} == b) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [31:0] scan_good(input logic [31:0] start);
    logic [31:0] b;
    for (b = start; b < {16'd0, total_cfg}; b++) begin
      if (!is_listed(b)) return b;
    end
    for (b = 32'd0; b < start; b++) begin
      if (!is_listed(b)) return b;
    end
    return NONE_ADDR;
  endfunction

  function automatic rsp_t predict_response(input req_t r);
    rsp_t        o;
    logic [31:0] g;
    logic [31:0] cur;
    o = '0;
    case (r.func)
      FUNC_CHECK: begin
        o.is_bad = is_listed({16'd0, r.blk});
      end
      FUNC_MARK: begin
        if (is_listed({16'd0, r.blk})) begin
          o.success = 1'b1;
        end else if (marked_blks.size() < MAX_ENTRIES) begin
          marked_blks.push_back(r.blk);
          o.success = 1'b1;
        end
      end
      FUNC_FIND: begin
        g = scan_good({16'd0, r.blk});
        if (g == NONE_ADDR) begin
          o.found = NONE_BLOCK;
        end else begin
          o.success = 1'b1;
          o.found   = g[15:0];
        end
      end
      default: begin
        o.success   = 1'b1;
        o.safe_addr = r.addr;
        if (r.to_nand) begin
          cur = r.addr >> BLK_SHIFT;
          if (is_listed(cur)) begin
            o.is_bad = 1'b1;
            g = scan_good(cur + 32'd1);
            if (g == NONE_ADDR) begin
              o.success   = 1'b0;
              o.safe_addr = NONE_ADDR;
            end else begin
              o.safe_addr = g << BLK_SHIFT;
            end
          end
        end
      end
    endcase
    return o;
  endfunction

  function automatic logic [15:0] pick_block();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 25 && marked_blks.size() != 0) begin
      return marked_blks[$urandom_range(0, marked_blks.size() - 1)];
    end
    if (sel < 70) return 16'($urandom_range(0, 255));
    if (sel < 85) return 16'(total_cfg - 16'd2 + 16'($urandom_range(0, 4)));
    return 16'($urandom());
  endfunction

  function automatic req_t random_req();
    req_t        r;
    int unsigned sel;
    logic [15:0] b;
    sel = $urandom_range(0, 99);
    if (sel < 28) r.func = FUNC_CHECK;
    else if (sel < 48) r.func = FUNC_MARK;
    else if (sel < 70) r.func = FUNC_FIND;
    else r.func = FUNC_SAFE;
    if (r.func == FUNC_MARK && $urandom_range(0, 4) != 0) begin
      r.blk = 16'($urandom_range(0, 399));
    end else begin
      r.blk = pick_block();
    end
    b = pick_block();
    if ($urandom_range(0, 2) == 0) r.addr = $urandom();
    else r.addr = {b[14:0], 17'($urandom())};
    r.to_nand = ($urandom_range(0, 9) != 0);
    return r;
  endfunction

  task automatic issue(input req_t r, input rsp_t e);
    pending_rsps.push_back(e);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid          <= 1'b1;
    req_ch.func           <= r.func;
    req_ch.block_number   <= r.blk;
    req_ch.byte_address   <= r.addr;
    req_ch.target_is_nand <= r.to_nand;
    @(posedge clk_i);
    while (req_ch.ready !== 1'b1) @(posedge clk_i);
  endtask

  task automatic write_total(input logic [15:0] v);
    req_ch.valid <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    total_cfg = v;
  endtask

  always @(posedge clk_i) begin
    rsp_t got;
    rsp_t want;
    if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      got = '{rsp_ch.block_is_bad, rsp_ch.success, rsp_ch.found_block, rsp_ch.safe_address};
      if (pending_rsps.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("response transfer with none expected: bad=%b ok=%b found=%h addr=%h",
                   got.is_bad, got.success, got.found, got.safe_addr);
        end
      end else begin
        want = pending_rsps.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch: expected bad=%b ok=%b found=%h addr=%h,",
                     want.is_bad, want.success, want.found, want.safe_addr,
                     " got bad=%b ok=%b found=%h addr=%h",
                     got.is_bad, got.success, got.found, got.safe_addr);
          end
        end
      end
    end
    rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  initial begin
    #20ms;
    $display("testbench failed");
    $finish;
  end

  initial begin
    dir_row_t row;
    req_t     r;
    rsp_t     e;
    int       k;
    int       seg;
    logic [15:0] seg_totals [RAND_SEGS];
    seg_totals = '{16'd256, 16'hFFFF, 16'd130, 16'd0, 16'd180, TOTAL_RESET};
    mismatch_cnt          = 0;
    total_cfg             = TOTAL_RESET;
    src_idle_pct          = 30;
    snk_idle_pct          = 57;
    rst_ni                = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    req_ch.valid          = 1'b0;
    req_ch.func           = FUNC_CHECK;
    req_ch.block_number   = '0;
    req_ch.byte_address   = '0;
    req_ch.target_is_nand = 1'b0;
    rsp_ch.ready          = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < N_DIR; k++) begin
      row = DIRECTED[k];
      if (row.wr_cfg) write_total(row.cfg_val);
      r = '{row.func, row.blk, row.addr, row.to_nand};
      e = predict_response(r);
      if (row.typed) e = row.rsp;
      issue(r, e);
    end

    for (seg = 0; seg < RAND_SEGS; seg++) begin
      if (seg == 2) begin
        src_idle_pct = 57;
        snk_idle_pct = 30;
      end else if (seg == 4) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      write_total(seg_totals[seg]);
      for (k = 0; k < SEG_ITEMS; k++) begin
        r = random_req();
        e = predict_response(r);
        issue(r, e);
      end
    end

    req_ch.valid <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
